### sv/drbg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbg_pkg
// shared types, constants and helper functions of the sha-256 counter drbg
// ----------------------------------------------------------------------------
package drbg_pkg;

   localparam int REQ_BYTES_W = 10;   // wide enough for any fill limit up to 512
   localparam int LIMIT_W     = 16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1024;
   localparam logic [LIMIT_W-1:0] FILLS_MAX   = 16'hFFFF;

   localparam logic KIND_ENTROPY = 1'b0;
   localparam logic KIND_FILL    = 1'b1;

   localparam logic [31:0] PAD_WORD      = 32'h8000_0000;
   localparam logic [31:0] LEN_TWO_HALF  = 32'd512;   // 64-byte message
   localparam logic [31:0] LEN_KEY_CTR   = 32'd320;   // 40-byte message

   localparam logic [7:0][31:0] SHA_IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667 };

   typedef enum logic [2:0] {
      ST_IDLE, ST_G1, ST_G2, ST_K1, ST_K2, ST_GEN, ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic                   kind;
      logic [31:0]            word;
      logic [REQ_BYTES_W-1:0] nbytes;
   } q_item_type;

   typedef struct packed {
      logic              start;
      logic [15:0][31:0] blk;
      logic [7:0][31:0]  iv;
   } sha_req_type;

   typedef struct packed {
      logic             done;
      logic [7:0][31:0] digest;
   } sha_rsp_type;

   function automatic logic [31:0] bswap(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] kround(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

endpackage

### sv/drbg_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbg interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface drbg_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] entropy_word;
   logic [8:0]  request_bytes;
   modport source (output valid, kind, entropy_word, request_bytes, input ready);
   modport sink   (input valid, kind, entropy_word, request_bytes, output ready);
endinterface

interface drbg_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] random_data;
   logic [3:0]  valid_bytes;
   logic        last;
   logic        status;
   modport source (output valid, random_data, valid_bytes, last, status, input ready);
   modport sink   (input valid, random_data, valid_bytes, last, status, output ready);
endinterface

interface drbg_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] reseed_limit;
   modport source (output valid, reseed_limit, input ready);
   modport sink   (input valid, reseed_limit, output ready);
endinterface

### sv/drbg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbg_front
// takes request items, clamps the fill size and hands them to the queue
// ----------------------------------------------------------------------------
module drbg_front #(
   parameter int MAX_FILL_BYTES = 256
) (
   drbg_req_if.sink             req,
   output logic                 push_valid,
   input  logic                 push_ready,
   output drbg_pkg::q_item_type push_item
);
   localparam logic [drbg_pkg::REQ_BYTES_W-1:0] MAX_B =
      drbg_pkg::REQ_BYTES_W'(MAX_FILL_BYTES);

   logic [drbg_pkg::REQ_BYTES_W-1:0] nb;

   always_comb begin
      nb = drbg_pkg::REQ_BYTES_W'(req.request_bytes);
      if (nb > MAX_B) nb = MAX_B;
   end

   assign push_valid       = req.valid;
   assign req.ready        = push_ready;
   assign push_item.kind   = req.kind;
   assign push_item.word   = req.entropy_word;
   assign push_item.nbytes = nb;
endmodule

### sv/drbg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbg_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module drbg_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  drbg_pkg::q_item_type push_item,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output drbg_pkg::q_item_type pop_item
);
   drbg_pkg::q_item_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_item   = mem_ff[rp_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) wp_ff <= ~wp_ff;
         if (do_pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wp_ff] <= push_item;
   end
endmodule

### sv/drbg_sha.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbg_sha
// sha-256 compression, one round per cycle
// ----------------------------------------------------------------------------
module drbg_sha (
   input  logic                  clock,
   input  logic                  reset,
   input  drbg_pkg::sha_req_type sreq,
   output drbg_pkg::sha_rsp_type srsp
);
   logic             busy_ff, fin_ff, done_ff;
   logic [5:0]       rnd_ff;
   logic [7:0][31:0] v_ff, hin_ff, dig_ff;
   logic [15:0][31:0] w_ff;
   logic [31:0]      t1, t2, s0, s1, wn, a, e;

   always_comb begin
      a  = v_ff[0];
      e  = v_ff[4];
      t1 = v_ff[7] + (drbg_pkg::rotr(e, 6) ^ drbg_pkg::rotr(e, 11) ^ drbg_pkg::rotr(e, 25))
         + ((e & v_ff[5]) ^ (~e & v_ff[6])) + drbg_pkg::kround(rnd_ff) + w_ff[0];
      t2 = (drbg_pkg::rotr(a, 2) ^ drbg_pkg::rotr(a, 13) ^ drbg_pkg::rotr(a, 22))
         + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      s0 = drbg_pkg::rotr(w_ff[1], 7) ^ drbg_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = drbg_pkg::rotr(w_ff[14], 17) ^ drbg_pkg::rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = w_ff[0] + s0 + w_ff[9] + s1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
         if (busy_ff) begin
            rnd_ff <= rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (sreq.start) begin
            busy_ff <= 1'b1;
            rnd_ff  <= 6'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         v_ff <= {v_ff[6:4], v_ff[3] + t1, v_ff[2:0], t1 + t2};
         w_ff <= {wn, w_ff[15:1]};
      end else if (sreq.start) begin
         v_ff   <= sreq.iv;
         hin_ff <= sreq.iv;
         w_ff   <= sreq.blk;
      end
      if (fin_ff) begin
         for (int i = 0; i < 8; i++) dig_ff[i] <= hin_ff[i] + v_ff[i];
      end
   end

   assign srsp.done   = done_ff;
   assign srsp.digest = dig_ff;
endmodule

### sv/drbg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbg_back
// entropy queue, seed/reseed/generate sequencer and result register
// ----------------------------------------------------------------------------
module drbg_back #(
   parameter int MAX_FILL_BYTES  = 256,
   parameter int WORDS_PER_GROUP = 6,
   parameter int FIFO_WORDS      = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  drbg_pkg::q_item_type         pop_item,
   input  logic [drbg_pkg::LIMIT_W-1:0] reseed_limit,
   drbg_rsp_if.source                   rsp
);
   localparam int CNT_W = $clog2(FIFO_WORDS + 1);
   localparam int IDX_W = $clog2(FIFO_WORDS);
   localparam int REM_W = $clog2(MAX_FILL_BYTES + 1);
   localparam logic [CNT_W-1:0] GRP   = CNT_W'(WORDS_PER_GROUP);
   localparam logic [CNT_W-1:0] GRP2  = CNT_W'(2 * WORDS_PER_GROUP);
   localparam logic [CNT_W-1:0] FULL  = CNT_W'(FIFO_WORDS);
   localparam logic [31:0]      GLEN  = 32'(WORDS_PER_GROUP * 32);

   drbg_pkg::back_state_type st_ff, st_in;
   logic [31:0]      fifo_ff [FIFO_WORDS];
   logic [31:0]      fifo_in [FIFO_WORDS];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0][31:0] key_ff, key_in, tmp1_ff, tmp1_in, tmp2_ff, tmp2_in;
   logic [7:0][31:0] mid_ff, mid_in, dig_ff, dig_in;
   logic [63:0]      ctr_ff, ctr_in, ctr_nx;
   logic [15:0]      fills_ff, fills_in;
   logic             seeded_ff, seeded_in, hbusy_ff, hbusy_in, seed_ff, seed_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [1:0]       chunk_ff, chunk_in;
   logic             ov_ff, ov_in, olast_ff, olast_in, ostat_ff, ostat_in;
   logic [63:0]      odata_ff, odata_in;
   logic [3:0]       obytes_ff, obytes_in;
   logic             out_free, do_reseed;
   logic [CNT_W-1:0] need;
   logic [REM_W-1:0] ccnt;
   logic [63:0]      chunk_raw;
   drbg_pkg::sha_req_type sreq;
   drbg_pkg::sha_rsp_type srsp;

   drbg_sha u_sha (.clock(clock), .reset(reset), .sreq(sreq), .srsp(srsp));

   assign out_free  = !ov_ff || rsp.ready;
   assign do_reseed = seeded_ff && (fills_ff > reseed_limit);
   assign need      = !seeded_ff ? GRP2 : (do_reseed ? GRP : '0);
   assign ctr_nx    = ctr_ff + 64'd1;
   assign ccnt      = (rem_ff > REM_W'(8)) ? REM_W'(8) : rem_ff;

   always_comb begin
      chunk_raw = {drbg_pkg::bswap(dig_ff[{chunk_ff, 1'b1}]),
                   drbg_pkg::bswap(dig_ff[{chunk_ff, 1'b0}])};
   end

   always_comb begin
      st_in     = st_ff;
      fifo_in   = fifo_ff;
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      tmp1_in   = tmp1_ff;
      tmp2_in   = tmp2_ff;
      mid_in    = mid_ff;
      dig_in    = dig_ff;
      ctr_in    = ctr_ff;
      fills_in  = fills_ff;
      seeded_in = seeded_ff;
      hbusy_in  = hbusy_ff;
      seed_in   = seed_ff;
      rem_in    = rem_ff;
      chunk_in  = chunk_ff;
      ov_in     = ov_ff && !rsp.ready;
      odata_in  = odata_ff;
      obytes_in = obytes_ff;
      olast_in  = olast_ff;
      ostat_in  = ostat_ff;
      pop_ready = 1'b0;
      sreq.start = 1'b0;
      sreq.blk   = '0;
      sreq.iv    = drbg_pkg::SHA_IV;

      // message block for the current hashing step
      case (st_ff)
         drbg_pkg::ST_G1, drbg_pkg::ST_G2: begin
            for (int i = 0; i < WORDS_PER_GROUP; i++) sreq.blk[i] = drbg_pkg::bswap(fifo_ff[i]);
            sreq.blk[WORDS_PER_GROUP] = drbg_pkg::PAD_WORD;
            sreq.blk[15] = GLEN;
         end
         drbg_pkg::ST_K1: begin
            for (int i = 0; i < 8; i++) begin
               sreq.blk[i]     = seed_ff ? tmp1_ff[i] : key_ff[i];
               sreq.blk[i + 8] = tmp2_ff[i];
            end
         end
         drbg_pkg::ST_K2: begin
            sreq.blk[0]  = drbg_pkg::PAD_WORD;
            sreq.blk[15] = drbg_pkg::LEN_TWO_HALF;
            sreq.iv      = mid_ff;
         end
         drbg_pkg::ST_GEN: begin
            for (int i = 0; i < 8; i++) sreq.blk[i] = key_ff[i];
            sreq.blk[8]  = drbg_pkg::bswap(ctr_nx[31:0]);
            sreq.blk[9]  = drbg_pkg::bswap(ctr_nx[63:32]);
            sreq.blk[10] = drbg_pkg::PAD_WORD;
            sreq.blk[15] = drbg_pkg::LEN_KEY_CTR;
         end
         default: sreq.blk = '0;
      endcase

      case (st_ff)
         drbg_pkg::ST_IDLE: begin
            if (pop_valid && out_free) begin
               pop_ready = 1'b1;
               if (pop_item.kind == drbg_pkg::KIND_ENTROPY) begin
                  if (cnt_ff < FULL) begin
                     fifo_in[cnt_ff[IDX_W-1:0]] = pop_item.word;
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end else begin
                  rem_in = pop_item.nbytes[REM_W-1:0];
                  if (cnt_ff < need) begin
                     ov_in = 1'b1; odata_in = '0; obytes_in = '0;
                     olast_in = 1'b1; ostat_in = 1'b1;
                  end else if (!seeded_ff) begin
                     seed_in = 1'b1;
                     st_in   = drbg_pkg::ST_G1;
                  end else if (do_reseed) begin
                     seed_in = 1'b0;
                     st_in   = drbg_pkg::ST_G2;
                  end else if (pop_item.nbytes == '0) begin
                     ov_in = 1'b1; odata_in = '0; obytes_in = '0;
                     olast_in = 1'b1; ostat_in = 1'b0;
                     if (fills_ff != drbg_pkg::FILLS_MAX) fills_in = fills_ff + 16'd1;
                  end else begin
                     st_in = drbg_pkg::ST_GEN;
                  end
               end
            end
         end
         drbg_pkg::ST_G1, drbg_pkg::ST_G2, drbg_pkg::ST_K1, drbg_pkg::ST_K2,
         drbg_pkg::ST_GEN: begin
            if (!hbusy_ff) begin
               sreq.start = 1'b1;
               hbusy_in   = 1'b1;
               if (st_ff == drbg_pkg::ST_G1 || st_ff == drbg_pkg::ST_G2) begin
                  // pop one group off the head of the entropy queue
                  for (int i = 0; i < FIFO_WORDS; i++)
                     fifo_in[i] = (i + WORDS_PER_GROUP < FIFO_WORDS) ?
                                  fifo_ff[(i + WORDS_PER_GROUP) % FIFO_WORDS] : '0;
                  cnt_in = cnt_ff - GRP;
               end
               if (st_ff == drbg_pkg::ST_GEN) ctr_in = ctr_nx;
            end else if (srsp.done) begin
               hbusy_in = 1'b0;
               case (st_ff)
                  drbg_pkg::ST_G1: begin
                     tmp1_in = srsp.digest; st_in = drbg_pkg::ST_G2;
                  end
                  drbg_pkg::ST_G2: begin
                     tmp2_in = srsp.digest; st_in = drbg_pkg::ST_K1;
                  end
                  drbg_pkg::ST_K1: begin
                     mid_in  = srsp.digest; st_in = drbg_pkg::ST_K2;
                  end
                  drbg_pkg::ST_K2: begin
                     key_in    = srsp.digest;
                     ctr_in    = '0;
                     fills_in  = '0;
                     seeded_in = 1'b1;
                     if (rem_ff == '0) st_in = drbg_pkg::ST_EMIT;
                     else              st_in = drbg_pkg::ST_GEN;
                  end
                  default: begin
                     dig_in   = srsp.digest;
                     chunk_in = '0;
                     st_in    = drbg_pkg::ST_EMIT;
                  end
               endcase
            end
         end
         drbg_pkg::ST_EMIT: begin
            if (out_free) begin
               ov_in     = 1'b1;
               ostat_in  = 1'b0;
               obytes_in = 4'(ccnt);
               for (int b = 0; b < 8; b++)
                  odata_in[8*b +: 8] = (REM_W'(b) < ccnt) ? chunk_raw[8*b +: 8] : 8'd0;
               olast_in = (rem_ff == ccnt);
               rem_in   = rem_ff - ccnt;
               chunk_in = chunk_ff + 2'd1;
               if (rem_ff == ccnt) begin
                  if (fills_ff != drbg_pkg::FILLS_MAX) fills_in = fills_ff + 16'd1;
                  st_in = drbg_pkg::ST_IDLE;
               end else if (chunk_ff == 2'd3) begin
                  st_in = drbg_pkg::ST_GEN;
               end
            end
         end
         default: st_in = drbg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= drbg_pkg::ST_IDLE;
         cnt_ff    <= '0;
         key_ff    <= '0;
         ctr_ff    <= '0;
         fills_ff  <= '0;
         seeded_ff <= 1'b0;
         hbusy_ff  <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         st_ff     <= st_in;
         cnt_ff    <= cnt_in;
         key_ff    <= key_in;
         ctr_ff    <= ctr_in;
         fills_ff  <= fills_in;
         seeded_ff <= seeded_in;
         hbusy_ff  <= hbusy_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      fifo_ff   <= fifo_in;
      tmp1_ff   <= tmp1_in;
      tmp2_ff   <= tmp2_in;
      mid_ff    <= mid_in;
      dig_ff    <= dig_in;
      seed_ff   <= seed_in;
      rem_ff    <= rem_in;
      chunk_ff  <= chunk_in;
      odata_ff  <= odata_in;
      obytes_ff <= obytes_in;
      olast_ff  <= olast_in;
      ostat_ff  <= ostat_in;
   end

   assign rsp.valid       = ov_ff;
   assign rsp.random_data = odata_ff;
   assign rsp.valid_bytes = obytes_ff;
   assign rsp.last        = olast_ff;
   assign rsp.status      = ostat_ff;
endmodule

### sv/sha256_counter_drbg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_counter_drbg
// sha-256 counter-mode random generator with a queued entropy source
// ----------------------------------------------------------------------------
//  channel | dir | payload                                       | accept
//  req     | in  | kind, entropy_word, request_bytes             | valid & ready
//  rsp     | out | random_data, valid_bytes, last, status        | valid & ready
//  csr     | in  | reseed_limit                                  | valid & ready
//
//  an entropy item is taken while the back end is idle; a fill costs one compression
//  per 32-byte block plus one 8-byte result per cycle while rsp is not stalled,
//  and seeding adds four compressions, reseeding three, all of them run on
//  the single round-per-cycle sha-256 unit
//  reset is synchronous; no clearing pass is needed
//  a two-entry queue lets requests land while the back end works or stalls
// ----------------------------------------------------------------------------
module sha256_counter_drbg #(
   parameter int MAX_FILL_BYTES  = 256,
   parameter int WORDS_PER_GROUP = 6,
   parameter int FIFO_WORDS      = 12
) (
   input  logic       clock,
   input  logic       reset,
   drbg_req_if.sink   req,
   drbg_rsp_if.source rsp,
   drbg_csr_if.sink   csr
);
   // reseed limit register, always writable
   logic [drbg_pkg::LIMIT_W-1:0] limit_ff;

   // front to queue, queue to back
   logic                 push_valid, push_ready, pop_valid, pop_ready;
   drbg_pkg::q_item_type push_item, pop_item;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= drbg_pkg::LIMIT_RESET;
      end else if (csr.valid) begin
         limit_ff <= csr.reseed_limit;
      end
   end

   // front: clamps request size, no state of its own
   drbg_front #(.MAX_FILL_BYTES(MAX_FILL_BYTES)) u_front (
      .req(req), .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item)
   );

   // queue keeps entropy words and fills in arrival order
   drbg_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item)
   );

   // back: entropy store, key/counter state, hash sequencing, result register
   drbg_back #(
      .MAX_FILL_BYTES(MAX_FILL_BYTES),
      .WORDS_PER_GROUP(WORDS_PER_GROUP),
      .FIFO_WORDS(FIFO_WORDS)
   ) u_back (
      .clock(clock), .reset(reset),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item),
      .reseed_limit(limit_ff), .rsp(rsp)
   );
endmodule

### sv/drbg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbg_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
module drbg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_data,
   input logic [3:0]  rsp_bytes,
   input logic        rsp_last,
   input logic        rsp_status
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bytes <= 4'd8)
      else $error("byte count out of range");

   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last && rsp_bytes == 4'd0 && rsp_data == 64'd0)
      else $error("bad error result");

   a_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_bytes == 4'd8 && !rsp_status)
      else $error("short chunk before last");
endmodule

bind sha256_counter_drbg drbg_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.random_data),
   .rsp_bytes(rsp.valid_bytes), .rsp_last(rsp.last), .rsp_status(rsp.status)
);
